### sv/wtws_pkg.sv
// Package: constants, codes, command/status types and helpers for the window selector
`timescale 1ns / 1ps
`default_nettype none
package wtws_pkg;

    localparam int SLOTS     = 8;
    localparam int DAY_MIN   = 1440;
    localparam int MAP_WORDS = 45;
    localparam int MAP_DEPTH = SLOTS * MAP_WORDS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int SLOT_IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W     = 11;
    localparam int KT_W      = KEY_W + 1;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_EVAL  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [2:0] ST_UNCHANGED = 3'd0;
    localparam logic [2:0] ST_CHANGED   = 3'd1;
    localparam logic [2:0] ST_NO_TARGET = 3'd2;
    localparam logic [2:0] ST_LOADED    = 3'd3;
    localparam logic [2:0] ST_REJECTED  = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    localparam logic [3:0] NIB_WILD = 4'hF;

    typedef struct packed {
        logic       capture;
        logic       sw_start;
        logic       load_fin;
        logic       ev_init;
        logic       ev_check;
        logic       ev_next;
        logic       clr_active;
        logic       set_res;
        logic [2:0] res_code;
        logic       push;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       slot_ok;
        logic       sw_done;
        logic       ev_hit;
        logic       ev_last;
        logic       out_free;
    } stat_t;

    // nibble-wise match of an HH:MM pattern against a BCD minute
    function automatic logic pat_match(input logic [15:0] pat, input logic [15:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (pat[4*i +: 4] != NIB_WILD && pat[4*i +: 4] != bcd[4*i +: 4]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // class key: minute value of the digits wildcarded in both patterns, others zeroed
    function automatic logic [KEY_W-1:0] key_minute(input logic [15:0] bcd,
                                                    input logic [3:0] both);
        logic [KEY_W-1:0] h1, h2, m1, m2, hh;
        h1 = both[3] ? {7'd0, bcd[15:12]} : '0;
        h2 = both[2] ? {7'd0, bcd[11:8]}  : '0;
        m1 = both[1] ? {7'd0, bcd[7:4]}   : '0;
        m2 = both[0] ? {7'd0, bcd[3:0]}   : '0;
        hh = (h1 << 3) + (h1 << 1) + h2;
        return (hh << 6) - (hh << 2) + (m1 << 3) + (m1 << 1) + m2;
    endfunction

    // advance a BCD HH:MM by one minute, wrapping at midnight
    function automatic logic [15:0] bcd_inc(input logic [15:0] b);
        logic [15:0] r;
        r = b;
        if (b[3:0] != 4'd9) begin
            r[3:0] = b[3:0] + 4'd1;
        end
        else begin
            r[3:0] = 4'd0;
            if (b[7:4] != 4'd5) begin
                r[7:4] = b[7:4] + 4'd1;
            end
            else begin
                r[7:4] = 4'd0;
                if (b[15:12] == 4'd2 && b[11:8] == 4'd3) begin
                    r[15:8] = 8'd0;
                end
                else if (b[11:8] == 4'd9) begin
                    r[11:8]  = 4'd0;
                    r[15:12] = b[15:12] + 4'd1;
                end
                else begin
                    r[11:8] = b[11:8] + 4'd1;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/wildcard_time_window_selector.sv
// Load sweeps the day four times (key table clear, end scan, arc warm-up, map write,
//   one minute per cycle); evaluate does one map RAM read per slot scanned.
// Throughput: one word at a time; the next word is taken once the result is registered.
// Reset: asynchronous active low; all slots unused, no active choice, no result pending.
// Top level: wildcard HH:MM schedule slot table and minute-of-day selector
`timescale 1ns / 1ps
`default_nettype none
module wildcard_time_window_selector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [2:0]  slot,
    input  wire logic        enabled,
    input  wire logic [15:0] dest_id,
    input  wire logic [15:0] start_pattern,
    input  wire logic [15:0] end_pattern,
    input  wire logic [10:0] minute,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [2:0]       sel_index,
    output logic [15:0]      sel_id
);
    import wtws_pkg::*;

    cmd_t  cmd;
    stat_t st;

    wtws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    wtws_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .req_type      (req_type),
        .slot          (slot),
        .enabled       (enabled),
        .dest_id       (dest_id),
        .start_pattern (start_pattern),
        .end_pattern   (end_pattern),
        .minute        (minute),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .sel_index     (sel_index),
        .sel_id        (sel_id)
    );
endmodule
`default_nettype wire

### sv/wtws_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module wtws_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/wtws_ctrl.sv
// Controller state machine: sequences load sweep, slot scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module wtws_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire wtws_pkg::stat_t st,
    output wtws_pkg::cmd_t      cmd
);
    import wtws_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_LFIN  = 3'd2;
    localparam logic [2:0] S_EVRD  = 3'd3;
    localparam logic [2:0] S_EVCHK = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (st.req)
                        REQ_LOAD:
                        begin
                            if (st.slot_ok)
                            begin
                                cmd.sw_start = 1'b1;
                                state_next   = S_SWEEP;
                            end
                            else
                            begin
                                cmd.set_res  = 1'b1;
                                cmd.res_code = ST_REJECTED;
                                state_next   = S_RESP;
                            end
                        end
                        REQ_EVAL:
                        begin
                            cmd.ev_init = 1'b1;
                            state_next  = S_EVRD;
                        end
                        REQ_CLEAR:
                        begin
                            cmd.clr_active = 1'b1;
                            cmd.set_res    = 1'b1;
                            cmd.res_code   = ST_CLEARED;
                            state_next     = S_RESP;
                        end
                        default:
                        begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = ST_NO_TARGET;
                            state_next   = S_RESP;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (st.sw_done)
                begin
                    state_next = S_LFIN;
                end
            end
            S_LFIN:
            begin
                cmd.load_fin = 1'b1;
                state_next   = S_RESP;
            end
            S_EVRD:
            begin
                state_next = S_EVCHK;
            end
            S_EVCHK:
            begin
                cmd.ev_check = 1'b1;
                if (st.ev_hit || st.ev_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.ev_next = 1'b1;
                    state_next  = S_EVRD;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### sv/wtws_dp.sv
// Datapath: minute sweep compiler, slot table, minute maps, active choice, result register
`timescale 1ns / 1ps
`default_nettype none
module wtws_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wtws_pkg::cmd_t       cmd,
    output wtws_pkg::stat_t           st,
    input  wire logic [1:0]           req_type,
    input  wire logic [2:0]           slot,
    input  wire logic                 enabled,
    input  wire logic [15:0]          dest_id,
    input  wire logic [15:0]          start_pattern,
    input  wire logic [15:0]          end_pattern,
    input  wire logic [10:0]          minute,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                status,
    output logic [2:0]                sel_index,
    output logic [15:0]               sel_id
);
    import wtws_pkg::*;

    localparam logic [10:0] LAST_MIN = 11'(DAY_MIN - 1);

    // captured word
    logic [15:0] sp_reg, ep_reg, id_reg;
    logic [2:0]  slot_reg;
    logic        en_reg;
    logic [10:0] mmod_reg;

    // slot table
    logic              used_reg [SLOTS];
    logic              sen_reg  [SLOTS];
    logic [15:0]       sid_reg  [SLOTS];

    // active choice
    logic               act_valid_reg;
    logic [SLOT_IW-1:0] act_slot_reg;
    logic [15:0]        act_id_reg;

    // sweep stage 0
    logic        run_reg;
    logic [1:0]  pass_reg;
    logic [10:0] t_reg;
    logic [15:0] bcd_reg;

    // sweep stage 1
    logic              s1_valid_reg, s1_ms_reg, s1_me_reg, s1_last_reg;
    logic [1:0]        s1_pass_reg;
    logic [10:0]       s1_t_reg;
    logic [KEY_W-1:0]  s1_key_reg;

    // key table forwarding of the write made in the previous cycle
    logic              fw_valid_reg;
    logic [KEY_W-1:0]  fw_key_reg;
    logic [10:0]       fw_t_reg;

    logic [10:0] r_reg;
    logic        full_reg, found_reg;
    logic [31:0] wbuf_reg;

    // eval scan and result
    logic [SLOT_IW-1:0] idx_reg;
    logic [2:0]  res_st_reg, out_st_reg;
    logic [2:0]  res_idx_reg, out_idx_reg;
    logic [15:0] res_id_reg, out_id_reg;
    logic        out_valid_reg;

    logic [3:0]        both;
    logic              ms0, me0;
    logic [KEY_W-1:0]  key0;

    logic              kt_we;
    logic [KEY_W-1:0]  kt_waddr;
    logic [KT_W-1:0]   kt_wdata, kt_rdata, look;
    logic              fw_hit, arc_ok, cov;
    logic [10:0]       arc_len, r_dec, r_cur;
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic [31:0]       map_wdata, map_rdata;
    logic [SLOT_IW-1:0] slot_ix;
    logic              elig, hit;
    logic [10:0]       mmod;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            both[i] = (sp_reg[4*i +: 4] == NIB_WILD) && (ep_reg[4*i +: 4] == NIB_WILD);
        end
    end

    assign ms0  = pat_match(sp_reg, bcd_reg);
    assign me0  = pat_match(ep_reg, bcd_reg);
    assign key0 = key_minute(bcd_reg, both);

    // stage 1: last end of the same class at or before this minute, around the clock
    assign fw_hit = fw_valid_reg && (fw_key_reg == s1_key_reg);
    assign look   = fw_hit ? {1'b1, fw_t_reg} : kt_rdata;
    assign arc_ok = s1_ms_reg && look[KT_W-1];
    assign arc_len = (look[10:0] > s1_t_reg) ? (look[10:0] - s1_t_reg)
                                             : 11'(12'(look[10:0]) + 12'(DAY_MIN)
                                                   - 12'(s1_t_reg));
    assign r_dec = (r_reg == 11'd0) ? 11'd0 : r_reg - 11'd1;
    assign r_cur = (arc_ok && arc_len > r_dec) ? arc_len : r_dec;
    assign cov   = full_reg || (r_cur != 11'd0);

    // pass 0 clears the key table by minute address; later passes record ends
    always_comb
    begin
        if (run_reg && pass_reg == 2'd0)
        begin
            kt_we    = 1'b1;
            kt_waddr = t_reg;
            kt_wdata = '0;
        end
        else
        begin
            kt_we    = s1_valid_reg && s1_me_reg;
            kt_waddr = s1_key_reg;
            kt_wdata = {1'b1, s1_t_reg};
        end
    end

    wtws_ram #(.W(KT_W), .D(DAY_MIN)) u_key_ram (
        .clk   (clk),
        .we    (kt_we),
        .waddr (kt_waddr),
        .wdata (kt_wdata),
        .raddr (key0),
        .rdata (kt_rdata)
    );

    assign slot_ix   = SLOT_IW'(slot_reg);
    assign map_we    = s1_valid_reg && (s1_pass_reg == 2'd3) && (s1_t_reg[4:0] == 5'd31);
    assign map_wdata = {cov, wbuf_reg[31:1]};
    assign map_waddr = MAP_AW'(MAP_AW'(slot_ix) * MAP_AW'(MAP_WORDS))
                     + MAP_AW'(s1_t_reg[10:5]);
    assign map_raddr = MAP_AW'(MAP_AW'(idx_reg) * MAP_AW'(MAP_WORDS))
                     + MAP_AW'(mmod_reg[10:5]);

    wtws_ram #(.W(32), .D(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign elig = used_reg[idx_reg] && sen_reg[idx_reg] && (sid_reg[idx_reg] != 16'd0);
    assign hit  = elig && map_rdata[mmod_reg[4:0]];
    assign mmod = (minute >= 11'(DAY_MIN)) ? minute - 11'(DAY_MIN) : minute;

    assign st.req      = req_type;
    assign st.slot_ok  = (7'(slot) < 7'(SLOTS));
    assign st.sw_done  = s1_valid_reg && s1_last_reg;
    assign st.ev_hit   = hit;
    assign st.ev_last  = (idx_reg == SLOT_IW'(SLOTS - 1));
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign sel_index = out_idx_reg;
    assign sel_id    = out_id_reg;

    // captured fields and sweep payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sp_reg   <= start_pattern;
            ep_reg   <= end_pattern;
            id_reg   <= dest_id;
            slot_reg <= slot;
            en_reg   <= enabled;
            mmod_reg <= mmod;
        end
        s1_ms_reg   <= ms0;
        s1_me_reg   <= me0;
        s1_pass_reg <= pass_reg;
        s1_t_reg    <= t_reg;
        s1_key_reg  <= key0;
        s1_last_reg <= (pass_reg == 2'd3) && (t_reg == LAST_MIN);
        fw_key_reg  <= kt_waddr;
        fw_t_reg    <= s1_t_reg;
        if (s1_valid_reg && s1_pass_reg == 2'd3)
        begin
            wbuf_reg <= {cov, wbuf_reg[31:1]};
        end
        if (cmd.set_res)
        begin
            res_st_reg  <= cmd.res_code;
            res_idx_reg <= 3'd0;
            res_id_reg  <= 16'd0;
        end
        else if (cmd.load_fin)
        begin
            res_st_reg  <= (full_reg || found_reg) ? ST_LOADED : ST_REJECTED;
            res_idx_reg <= 3'd0;
            res_id_reg  <= 16'd0;
        end
        else if (cmd.ev_check)
        begin
            if (hit)
            begin
                res_st_reg  <= (act_valid_reg && act_slot_reg == idx_reg
                                && act_id_reg == sid_reg[idx_reg]) ? ST_UNCHANGED : ST_CHANGED;
                res_idx_reg <= 3'(idx_reg);
                res_id_reg  <= sid_reg[idx_reg];
            end
            else
            begin
                res_st_reg  <= ST_NO_TARGET;
                res_idx_reg <= 3'd0;
                res_id_reg  <= 16'd0;
            end
        end
        if (cmd.push)
        begin
            out_st_reg  <= res_st_reg;
            out_idx_reg <= res_idx_reg;
            out_id_reg  <= res_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            pass_reg      <= 2'd0;
            t_reg         <= 11'd0;
            bcd_reg       <= 16'd0;
            s1_valid_reg  <= 1'b0;
            fw_valid_reg  <= 1'b0;
            r_reg         <= 11'd0;
            full_reg      <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            act_valid_reg <= 1'b0;
            act_slot_reg  <= '0;
            act_id_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i] <= 1'b0;
                sen_reg[i]  <= 1'b0;
                sid_reg[i]  <= 16'd0;
            end
        end
        else
        begin
            if (cmd.sw_start)
            begin
                run_reg   <= 1'b1;
                pass_reg  <= 2'd0;
                t_reg     <= 11'd0;
                bcd_reg   <= 16'd0;
                r_reg     <= 11'd0;
                full_reg  <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (t_reg == LAST_MIN)
                begin
                    t_reg   <= 11'd0;
                    bcd_reg <= 16'd0;
                    if (pass_reg == 2'd3)
                    begin
                        run_reg <= 1'b0;
                    end
                    else
                    begin
                        pass_reg <= pass_reg + 2'd1;
                    end
                end
                else
                begin
                    t_reg   <= t_reg + 11'd1;
                    bcd_reg <= bcd_inc(bcd_reg);
                end
            end
            s1_valid_reg <= run_reg && (pass_reg != 2'd0);
            fw_valid_reg <= !(run_reg && pass_reg == 2'd0) && kt_we;

            if (s1_valid_reg)
            begin
                if (s1_pass_reg == 2'd1 && s1_ms_reg && s1_me_reg)
                begin
                    full_reg <= 1'b1;
                end
                if (s1_pass_reg != 2'd1)
                begin
                    r_reg <= r_cur;
                    if (arc_ok)
                    begin
                        found_reg <= 1'b1;
                    end
                end
            end

            if (cmd.load_fin)
            begin
                used_reg[slot_ix] <= full_reg || found_reg;
                sen_reg[slot_ix]  <= (full_reg || found_reg) && en_reg;
                sid_reg[slot_ix]  <= (full_reg || found_reg) ? id_reg : 16'd0;
            end

            if (cmd.ev_init)
            begin
                idx_reg <= '0;
            end
            else if (cmd.ev_next)
            begin
                idx_reg <= idx_reg + SLOT_IW'(1);
            end

            if (cmd.ev_check && hit)
            begin
                act_valid_reg <= 1'b1;
                act_slot_reg  <= idx_reg;
                act_id_reg    <= sid_reg[idx_reg];
            end
            else if (cmd.clr_active)
            begin
                act_valid_reg <= 1'b0;
                act_slot_reg  <= '0;
                act_id_reg    <= 16'd0;
            end

            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire
